// ===== rtl/core/qws_pkg.sv =====
// qws_pkg: constants and types shared by the quoted word splitter.
// Depends on nothing; imported by the core and its port checker.
package qws_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned UserW = 2;

	// byte codes seen by the splitter
	localparam logic [CharW-1:0] ChSquote = 8'h27;
	localparam logic [CharW-1:0] ChDquote = 8'h22;
	localparam logic [CharW-1:0] ChBslash = 8'h5C;
	localparam logic [CharW-1:0] ChSpace  = 8'h20;
	localparam logic [CharW-1:0] ChN      = 8'h6E;
	localparam logic [CharW-1:0] ChT      = 8'h74;
	localparam logic [CharW-1:0] ChLf     = 8'h0A;
	localparam logic [CharW-1:0] ChTab    = 8'h09;
	localparam logic [CharW-1:0] ChCr     = 8'h0D;

	// bit positions inside the result tuser
	localparam int unsigned UserCharValid = 0;
	localparam int unsigned UserStringEnd = 1;

	// word parser flags
	typedef struct packed {
		logic in_word;
		logic in_quote;
		logic quote_is_double;
		logic escape_pending;
	} qws_state_t;

	localparam qws_state_t StateIdle = '{default: 1'b0};

	// ASCII whitespace: space, TAB, LF, VT, FF, CR
	function automatic logic is_ws(input logic [CharW-1:0] c);
		is_ws = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
	endfunction

endpackage

// ===== rtl/core/quoted_word_splitter.sv =====
// quoted_word_splitter: shell-style word splitting of a byte stream.
// Depends on qws_pkg (byte codes, state type, whitespace test).
//
// channel  dir  tdata[7:0]  tuser (bit 0 up)              tlast
// s_axis   in   in_char     -                             last_char
// m_axis   out  out_char    char_valid, string_end        token_end
//
// One byte per cycle while m_axis is not stalled; a byte passes the input register
// and then the result register. The parser flags are updated in the same cycle that a
// byte leaves the input register, which sets the one-byte-per-cycle figure.
// Bytes that produce no result are dropped without occupying the output.
// arst_n clears both stage valids and the parser flags; data regs keep.
// A stall on m_axis holds the result and backs up into the input register.
module quoted_word_splitter
	import qws_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [CharW-1:0] s_axis_tdata,  // [7:0] in_char
	input  logic             s_axis_tlast,  // last_char
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [CharW-1:0] m_axis_tdata,  // [7:0] out_char
	output logic [UserW-1:0] m_axis_tuser,  // [0] char_valid, [1] string_end
	output logic             m_axis_tlast   // token_end
);

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;
	logic             valid_s2;
	logic [CharW-1:0] char_s2;
	logic             cvalid_s2;
	logic             tend_s2;
	logic             send_s2;
	qws_state_t       st_q;
	qws_state_t       st_next;

	logic             active;
	logic             is_sq;
	logic             is_dq;
	logic             is_bs;
	logic             is_sp;
	logic             space_end;
	logic             emit;
	logic [CharW-1:0] ch;
	logic             tend;
	logic             has_res;
	logic             out_free;
	logic             adv;

	// decode the byte in the input register against the parser flags
	always_comb begin
		active    = st_q.in_word || !is_ws(char_s1);
		is_sq     = (char_s1 == ChSquote);
		is_dq     = (char_s1 == ChDquote);
		is_bs     = (char_s1 == ChBslash);
		is_sp     = (char_s1 == ChSpace);
		emit      = 1'b0;
		ch        = char_s1;
		space_end = 1'b0;
		st_next   = st_q;
		st_next.in_word = active;
		if (is_sq || is_dq) begin
			if (st_q.escape_pending) begin
				st_next.escape_pending = 1'b0;
				emit = 1'b1;
			end else if (st_q.in_quote) begin
				if (is_dq == st_q.quote_is_double) begin
					st_next.in_quote = 1'b0;
				end else begin
					emit = 1'b1;
				end
			end else begin
				st_next.in_quote        = 1'b1;
				st_next.quote_is_double = is_dq;
			end
		end else if (is_bs) begin
			if (st_q.escape_pending) begin
				st_next.escape_pending = 1'b0;
				emit = 1'b1;
			end else begin
				st_next.escape_pending = 1'b1;
			end
		end else if (is_sp) begin
			if (st_q.in_quote || st_q.escape_pending) begin
				st_next.escape_pending = 1'b0;
				emit = 1'b1;
			end else begin
				space_end = 1'b1;
			end
		end else begin
			emit = 1'b1;
			if (st_q.escape_pending) begin
				st_next.escape_pending = 1'b0;
				if (char_s1 == ChN) begin
					ch = ChLf;
				end else if (char_s1 == ChT) begin
					ch = ChTab;
				end
			end
		end
		// nothing happens to the flags while skipping whitespace
		if (!active) begin
			emit    = 1'b0;
			st_next = StateIdle;
		end
		tend = active && (space_end || last_s1);
		if (tend || last_s1) begin
			st_next = StateIdle;
		end
		has_res = emit || tend || last_s1;
	end

	// handshake: stage 1 moves when the result register can take it or its byte has no result
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && (out_free || !has_res);
	assign s_axis_tready = !valid_s1 || adv;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= StateIdle;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				st_q <= st_next;
			end
			if (adv && has_res) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv && has_res) begin
			char_s2   <= emit ? ch : '0;
			cvalid_s2 <= emit;
			tend_s2   <= tend;
			send_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = char_s2;
	assign m_axis_tlast  = tend_s2;
	always_comb begin
		m_axis_tuser                = '0;
		m_axis_tuser[UserCharValid] = cvalid_s2;
		m_axis_tuser[UserStringEnd] = send_s2;
	end

endmodule

// ===== rtl/core/qws_port_checker.sv =====
// qws_port_checker: port-level assertions for quoted_word_splitter.
// Depends on qws_pkg; attached to the top level by the bind below.
module qws_port_checker
	import qws_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [CharW-1:0] s_axis_tdata,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [CharW-1:0] m_axis_tdata,
	input logic [UserW-1:0] m_axis_tuser,
	input logic             m_axis_tlast
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// every beat carries a byte, a word end or a string end
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[UserCharValid] || m_axis_tlast
		|| m_axis_tuser[UserStringEnd])
		else $error("empty result beat");

	// data is zero when no byte is carried
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[UserCharValid] |-> m_axis_tdata == '0)
		else $error("nonzero data without char_valid");

	// an offered input beat holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
		&& $stable(s_axis_tlast))
		else $error("input beat changed while waiting");

	// a word ends together with a byte only on the last byte of the string
	a_tend_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[UserCharValid]
		|-> m_axis_tuser[UserStringEnd])
		else $error("word end carried with a byte before string end");

endmodule

bind quoted_word_splitter qws_port_checker u_qws_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
